// ===== src/mpf_pkg.sv =====
// ----------------------------------------------------------------------------
// mpf_pkg: shared types and constants of the PUBLISH frame builder
// Job descriptor passed from the front end to the byte emitter, result word
// layout, queue depths and protocol constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpf_pkg;

  localparam logic [7:0]  HDR_PUBLISH = 8'h30;
  localparam logic [28:0] MAX_REMAIN  = 29'h0FFF_FFFF;
  localparam int          JOB_BYTES   = 9;   // longest burst from one input word
  localparam int          JQ_DEPTH    = 2;
  localparam int          JQ_AW       = $clog2(JQ_DEPTH);
  localparam int          OQ_DEPTH    = 2;
  localparam int          OQ_AW       = $clog2(OQ_DEPTH);

  // Bytes are emitted from index 0 upward.
  typedef struct packed {
    logic [3:0]                  nbytes;
    logic [JOB_BYTES-1:0][7:0]   bytes;
    logic                        pkt_end;  // last byte closes the packet
    logic                        err;
  } job_t;

  typedef struct packed {
    logic [7:0] data;
    logic       pkt_end;
    logic       run_last;
    logic       err;
  } ent_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_TOPIC = 3'b010,
    PH_MSG   = 3'b100
  } phase_t;

endpackage

// ===== src/mpf_front.sv =====
// ----------------------------------------------------------------------------
// mpf_front: input word classifier and packet state
// Tracks the open packet, builds the header bytes on a start word and turns
// every accepted input word into one job descriptor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpf_front import mpf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic        func,
  input  logic [7:0]  data_byte,
  input  logic [15:0] topic_length,
  input  logic [27:0] message_length,
  input  logic [1:0]  qos,
  output job_t        job
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] pid_r, pid_nxt;
  logic [15:0] tleft_r, tleft_nxt;
  logic [27:0] mleft_r, mleft_nxt;
  logic        wid_r, wid_nxt;

  logic [28:0]      rem;
  logic [3:0][6:0]  grp;
  logic [2:0]       nvlb;
  logic             qnz;

  assign qnz  = (qos != 2'd0);
  assign rem  = 29'd2 + {13'd0, topic_length} + {1'b0, message_length}
              + (qnz ? 29'd2 : 29'd0);
  assign grp  = rem[27:0];
  assign nvlb = (rem[27:7] == '0)  ? 3'd1 :
                (rem[27:14] == '0) ? 3'd2 :
                (rem[27:21] == '0) ? 3'd3 : 3'd4;

  always_comb begin
    logic [3:0]  k;
    logic [15:0] tdec;
    logic [27:0] mdec;
    phase_nxt = phase_r;
    pid_nxt   = pid_r;
    tleft_nxt = tleft_r;
    mleft_nxt = mleft_r;
    wid_nxt   = wid_r;
    job       = '0;
    k         = 4'd0;
    tdec      = tleft_r - 16'd1;
    mdec      = mleft_r - 28'd1;
    if (!func) begin
      if (rem > MAX_REMAIN) begin
        phase_nxt  = PH_IDLE;
        job.nbytes = 4'd1;
        job.err    = 1'b1;
      end else begin
        wid_nxt   = qnz;
        tleft_nxt = topic_length;
        mleft_nxt = message_length;
        job.bytes[k] = HDR_PUBLISH;
        k = k + 4'd1;
        for (int i = 0; i < 4; i++) begin
          if (3'(i) < nvlb) begin
            job.bytes[k] = {(3'(i) < nvlb - 3'd1), grp[i]};
            k = k + 4'd1;
          end
        end
        job.bytes[k] = topic_length[15:8];
        k = k + 4'd1;
        job.bytes[k] = topic_length[7:0];
        k = k + 4'd1;
        if (topic_length == 16'd0) begin
          // empty topic: identifier and possibly the whole packet right away
          if (qnz) begin
            job.bytes[k] = pid_r[15:8];
            k = k + 4'd1;
            job.bytes[k] = pid_r[7:0];
            k = k + 4'd1;
            pid_nxt = pid_r + 16'd1;
          end
          job.pkt_end = (message_length == 28'd0);
          phase_nxt   = (message_length == 28'd0) ? PH_IDLE : PH_MSG;
        end else begin
          phase_nxt = PH_TOPIC;
        end
        job.nbytes = k;
      end
    end else begin
      unique case (phase_r)
        PH_TOPIC: begin
          job.bytes[0] = data_byte;
          k            = 4'd1;
          tleft_nxt    = tdec;
          if (tdec == 16'd0) begin
            if (wid_r) begin
              job.bytes[1] = pid_r[15:8];
              job.bytes[2] = pid_r[7:0];
              k            = 4'd3;
              pid_nxt      = pid_r + 16'd1;
            end
            job.pkt_end = (mleft_r == 28'd0);
            phase_nxt   = (mleft_r == 28'd0) ? PH_IDLE : PH_MSG;
          end
          job.nbytes = k;
        end
        PH_MSG: begin
          job.bytes[0] = data_byte;
          job.nbytes   = 4'd1;
          mleft_nxt    = mdec;
          job.pkt_end  = (mdec == 28'd0);
          if (mdec == 28'd0) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          // byte with no open packet
          job.nbytes = 4'd1;
          job.err    = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pid_r   <= '0;
      tleft_r <= '0;
      mleft_r <= '0;
      wid_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pid_r   <= pid_nxt;
      tleft_r <= tleft_nxt;
      mleft_r <= mleft_nxt;
      wid_r   <= wid_nxt;
    end
  end

endmodule

// ===== src/mpf_job_queue.sv =====
// ----------------------------------------------------------------------------
// mpf_job_queue: short job queue between front end and byte emitter
// Registered full/valid flags so neither side sees the other combinationally.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpf_job_queue import mpf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  job_t wr_job,
  output logic full,
  input  logic rd,
  output logic valid,
  output job_t rd_job
);

  job_t               mem_r [JQ_DEPTH];
  logic [JQ_AW-1:0]   wp_r, wp_nxt;
  logic [JQ_AW-1:0]   rp_r, rp_nxt;
  logic [JQ_AW:0]     cnt_r, cnt_nxt;

  assign full   = (cnt_r == (JQ_AW+1)'(JQ_DEPTH));
  assign valid  = (cnt_r != '0);
  assign rd_job = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr) begin
      wp_nxt = (wp_r == JQ_AW'(JQ_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (rd) begin
      rp_nxt = (rp_r == JQ_AW'(JQ_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_job;
    end
  end

endmodule

// ===== src/mpf_back.sv =====
// ----------------------------------------------------------------------------
// mpf_back: byte emitter and result queue
// Unrolls one job per burst into result words, one byte per cycle while the
// output queue has room, and keeps them in a small output queue for the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpf_back import mpf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  job_t       q_job,
  output logic       q_rd,
  output logic       empty,
  input  logic       pop,
  output ent_t       head
);

  logic                        cur_valid_r, cur_valid_nxt;
  logic [JOB_BYTES-1:0][7:0]   cur_bytes_r, cur_bytes_nxt;
  logic [3:0]                  cur_left_r, cur_left_nxt;
  logic                        cur_end_r, cur_end_nxt;
  logic                        cur_err_r, cur_err_nxt;

  ent_t              oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0]  owp_r, owp_nxt;
  logic [OQ_AW-1:0]  orp_r, orp_nxt;
  logic [OQ_AW:0]    ocnt_r, ocnt_nxt;

  logic  pop_ok, room, emit, last;
  ent_t  ent;

  assign empty  = (ocnt_r == '0);
  assign head   = oq_r[orp_r];
  assign pop_ok = pop && !empty;
  assign room   = (ocnt_r != (OQ_AW+1)'(OQ_DEPTH)) || pop_ok;
  assign emit   = cur_valid_r && room;
  assign last   = (cur_left_r == 4'd1);
  assign q_rd   = q_valid && (!cur_valid_r || (emit && last));

  assign ent.data     = cur_bytes_r[0];
  assign ent.pkt_end  = cur_end_r && last;
  assign ent.run_last = last;
  assign ent.err      = cur_err_r;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_bytes_nxt = cur_bytes_r;
    cur_left_nxt  = cur_left_r;
    cur_end_nxt   = cur_end_r;
    cur_err_nxt   = cur_err_r;
    if (q_rd) begin
      cur_valid_nxt = 1'b1;
      cur_bytes_nxt = q_job.bytes;
      cur_left_nxt  = q_job.nbytes;
      cur_end_nxt   = q_job.pkt_end;
      cur_err_nxt   = q_job.err;
    end else if (emit) begin
      cur_valid_nxt = !last;
      cur_bytes_nxt = cur_bytes_r >> 8;
      cur_left_nxt  = cur_left_r - 4'd1;
    end
  end

  always_comb begin
    owp_nxt  = owp_r;
    orp_nxt  = orp_r;
    ocnt_nxt = ocnt_r;
    if (emit) begin
      owp_nxt = (owp_r == OQ_AW'(OQ_DEPTH - 1)) ? '0 : owp_r + 1'b1;
    end
    if (pop_ok) begin
      orp_nxt = (orp_r == OQ_AW'(OQ_DEPTH - 1)) ? '0 : orp_r + 1'b1;
    end
    if (emit && !pop_ok) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (pop_ok && !emit) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      cur_left_r  <= '0;
      owp_r       <= '0;
      orp_r       <= '0;
      ocnt_r      <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      cur_left_r  <= cur_left_nxt;
      owp_r       <= owp_nxt;
      orp_r       <= orp_nxt;
      ocnt_r      <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_bytes_r <= cur_bytes_nxt;
    cur_end_r   <= cur_end_nxt;
    cur_err_r   <= cur_err_nxt;
    if (emit) begin
      oq_r[owp_r] <= ent;
    end
  end

  a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cur_left_r != 4'd0))
    else $error("active burst with no bytes left");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r && cur_err_r) |-> (cur_left_r == 4'd1))
    else $error("error burst longer than one word");

  a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !last) |=> cur_valid_r)
    else $error("burst dropped before its last byte");

  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= (OQ_AW+1)'(OQ_DEPTH))
    else $error("result queue overflow");

endmodule

// ===== src/mqtt_publish_framer.sv =====
// ----------------------------------------------------------------------------
// mqtt_publish_framer: PUBLISH frame builder, byte stream out
// Front end tracks the open packet and builds header bursts; a byte emitter
// drains them one byte per cycle, while the result queue has room, into that queue.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive in_* and raise push; the word is
//   taken on a clock edge with push high and full low. func = 0 opens a
//   packet (topic_length, message_length, qos); func = 1 carries one topic or
//   message byte.
//   Result side is a queue read port: while empty is low the oldest result
//   (out_byte, out_packet_end, out_run_last, out_error) is presented; it is
//   taken on an edge with pop high.
//   A start word yields 4 to 9 bytes (0x30, 1-4 length bytes, topic length,
//   optional packet identifier); a data word yields 1 byte, or 3 when the
//   identifier follows the last topic byte. Error words yield one result.
//   A word passes through the job queue, the emitter's burst register and the result queue.
//   Throughput: one result per cycle while the result queue has room, set by
//   the single-byte emitter; data streams run at one word per cycle,
//   header bursts hold full high while the two-entry job queue drains.
//   Reset (rst_n low, synchronous) empties both queues, closes any packet
//   and sets the packet identifier to zero.
//   When pop stays low the result queue fills, the emitter stops, the job
//   queue fills and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mqtt_publish_framer import mpf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_func,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_topic_length,
  input  logic [27:0] in_message_length,
  input  logic [1:0]  in_qos,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_packet_end,
  output logic        out_run_last,
  output logic        out_error
);

  logic accept;
  job_t front_job;   // job built from the word at the input
  job_t q_job;       // job at the head of the queue
  logic q_valid, q_rd;
  ent_t head;

  assign accept = push && !full;

  mpf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .func           (in_func),
    .data_byte      (in_data_byte),
    .topic_length   (in_topic_length),
    .message_length (in_message_length),
    .qos            (in_qos),
    .job            (front_job)
  );

  mpf_job_queue u_jq (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (accept),
    .wr_job (front_job),
    .full   (full),
    .rd     (q_rd),
    .valid  (q_valid),
    .rd_job (q_job)
  );

  mpf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_job   (q_job),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .head    (head)
  );

  assign out_byte       = head.data;
  assign out_packet_end = head.pkt_end;
  assign out_run_last   = head.run_last;
  assign out_error      = head.err;

endmodule
